// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL of the page allocator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check an implication on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ===== rtl/phpfl_pkg.sv =====
// Shared widths and codes of the per-hart page free-list allocator.
package phpfl_pkg;

   localparam int ADDR_W     = 56;
   localparam int PAGE_SHIFT = 12;
   localparam int FIRST_W    = 44;
   localparam int END_W      = 45;
   localparam int HART_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 45;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NOMEM   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BADADDR = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_PAGE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_PAGE   = 1'd1;

   localparam logic [FIRST_W-1:0] FIRST_PAGE_RESET = 44'd524288;
   localparam logic [END_W-1:0]   END_PAGE_RESET   = 45'd557056;

endpackage

// ===== rtl/phpfl_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module phpfl_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write one word, read one word, both on the clock edge
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/per_hart_page_free_list.sv =====
// Per-hart LIFO page allocator: head registers per hart, next links in one RAM.
// Sequence: a free goes through CHK_LO, CHK_HI and FIN; an alloc spends one LOOK per hart
// looked at, own list first, then LINK and FIN on a hit, or FIN alone when stealing fails.
// Requests: one word at a time, taken only in idle; the pace is set by the scan over the
// head registers, the shared 45-bit adder/subtractor and stalls on the response channel.
// Reset: synchronous; all lists empty, page bounds at their defaults, no clearing pass.
`include "assert_macros.svh"

module per_hart_page_free_list
   import phpfl_pkg::*;
#(
   parameter int NUM_HARTS = 8,
   parameter int NUM_PAGES = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [HART_W-1:0]     req_hart,
   input  logic [ADDR_W-1:0]     req_page_address,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [ADDR_W-1:0]     rsp_alloc_address,
   // configuration writes
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int HW     = $clog2(NUM_HARTS);
   localparam int IDX_W  = $clog2(NUM_PAGES);
   localparam int HCMP_W = (HW + 1 > HART_W) ? HW + 1 : HART_W;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } link_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHK_LO,
      ST_CHK_HI,
      ST_LOOK,
      ST_LINK,
      ST_FIN
   } state_type;

   state_type           state_ff;
   logic [FIRST_W-1:0]  first_ff;
   logic [END_W-1:0]    end_ff;
   link_type            head_ff [NUM_HARTS];

   logic                func_ff;
   logic [HART_W-1:0]   hart_ff;
   logic [FIRST_W-1:0]  page_ff;
   logic [FIRST_W-1:0]  diff_ff;
   logic                bad_ff;
   logic [HW-1:0]       sel_ff;
   logic                own_ff;
   logic [IDX_W-1:0]    idx_ff;
   logic [STATUS_W-1:0] res_status_ff;
   logic [ADDR_W-1:0]   res_addr_ff;

   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;

   logic                hart_ok;
   logic                slot_free;
   link_type            cur_head;
   logic                skip_own;
   logic                take;
   logic                push;
   logic [END_W-1:0]    au_a;
   logic [END_W-1:0]    au_b;
   logic                au_sub;
   logic [END_W:0]      au_sum;
   link_type            ram_rd_data;
   logic [STATUS_W-1:0] fin_status;

   assign req_ready = (state_ff == ST_IDLE);
   assign hart_ok   = HCMP_W'(req_hart) < HCMP_W'(NUM_HARTS);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   // examine the head of the selected hart's list
   assign cur_head = head_ff[sel_ff];
   assign skip_own = !own_ff && (HCMP_W'(sel_ff) == HCMP_W'(hart_ff));
   assign take     = cur_head.valid && !skip_own;
   assign push     = (state_ff == ST_FIN) && slot_free && (func_ff == FUNC_FREE) && !bad_ff;

   assign fin_status = (func_ff == FUNC_FREE) ? (bad_ff ? STATUS_BADADDR : STATUS_OK)
                                              : res_status_ff;

   // shared adder/subtractor: bound checks on free, address build on alloc
   always_comb begin
      au_a   = {1'b0, page_ff};
      au_b   = {1'b0, first_ff};
      au_sub = 1'b1;
      case (state_ff)
         ST_CHK_HI: begin
            au_b = end_ff;
         end
         ST_LINK: begin
            au_a   = {1'b0, first_ff};
            au_b   = END_W'(idx_ff);
            au_sub = 1'b0;
         end
         default: begin
         end
      endcase
      au_sum = {1'b0, au_a} + {1'b0, au_b ^ {END_W{au_sub}}} + (END_W + 1)'(au_sub);
   end

   // next-link memory, indexed by page index
   phpfl_ram #(
      .WIDTH (IDX_W + 1),
      .DEPTH (NUM_PAGES)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (idx_ff),
      .wr_data (cur_head),
      .rd_en   ((state_ff == ST_LOOK) && take),
      .rd_addr (cur_head.idx),
      .rd_data (ram_rd_data)
   );

   // take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= FIRST_PAGE_RESET;
         end_ff   <= END_PAGE_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_FIRST_PAGE: first_ff <= csr_wdata[FIRST_W-1:0];
            CSR_END_PAGE:   end_ff   <= csr_wdata[END_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer, list heads and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int h = 0; h < NUM_HARTS; h++) begin
            head_ff[h].valid <= 1'b0;
         end
      end else begin
         // drop the response word once taken, unless finish loads the next one
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  func_ff       <= req_func;
                  hart_ff       <= req_hart;
                  page_ff       <= req_page_address[ADDR_W-1:PAGE_SHIFT];
                  bad_ff        <= (req_page_address[PAGE_SHIFT-1:0] != '0) || !hart_ok;
                  sel_ff        <= hart_ok ? HW'(req_hart) : '0;
                  own_ff        <= hart_ok;
                  res_status_ff <= STATUS_OK;
                  res_addr_ff   <= '0;
                  state_ff      <= (req_func == FUNC_FREE) ? ST_CHK_LO : ST_LOOK;
               end
            end
            ST_CHK_LO: begin
               // page below first page
               bad_ff   <= bad_ff || !au_sum[END_W];
               diff_ff  <= au_sum[FIRST_W-1:0];
               state_ff <= ST_CHK_HI;
            end
            ST_CHK_HI: begin
               // page at or past end page, or index past the link memory
               bad_ff   <= bad_ff || au_sum[END_W] || (diff_ff >= FIRST_W'(NUM_PAGES));
               idx_ff   <= diff_ff[IDX_W-1:0];
               state_ff <= ST_FIN;
            end
            ST_LOOK: begin
               if (take) begin
                  idx_ff   <= cur_head.idx;
                  state_ff <= ST_LINK;
               end else if (own_ff) begin
                  own_ff <= 1'b0;
                  sel_ff <= '0;
               end else if (sel_ff == HW'(NUM_HARTS - 1)) begin
                  res_status_ff <= STATUS_NOMEM;
                  state_ff      <= ST_FIN;
               end else begin
                  sel_ff <= sel_ff + HW'(1);
               end
            end
            ST_LINK: begin
               // advance the head past the popped page and build its address
               head_ff[sel_ff] <= ram_rd_data;
               res_addr_ff     <= {au_sum[FIRST_W-1:0], {PAGE_SHIFT{1'b0}}};
               state_ff        <= ST_FIN;
            end
            ST_FIN: begin
               if (slot_free) begin
                  if (push) begin
                     head_ff[sel_ff] <= '{valid: 1'b1, idx: idx_ff};
                  end
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= fin_status;
                  rsp_addr_ff   <= res_addr_ff;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_alloc_address = rsp_addr_ff;

   `ASSERT_CLK(a_push_only_good_free, clock, reset, push |-> (func_ff == FUNC_FREE) && !bad_ff && (state_ff == ST_FIN), "link write outside a good free")
   `ASSERT_CLK(a_scan_in_range, clock, reset, (state_ff == ST_LOOK) |-> (HCMP_W'(sel_ff) < HCMP_W'(NUM_HARTS)), "scan index past last hart")
   `ASSERT_CLK(a_link_after_look, clock, reset, (state_ff == ST_LINK) |-> ($past(state_ff) == ST_LOOK), "link update without a head read")
   `ASSERT_CLK(a_rsp_from_fin, clock, reset, $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FIN), "response word raised outside finish")
   `ASSERT_NEVER(a_alloc_fail_addr, clock, reset, rsp_valid_ff && (rsp_status_ff != STATUS_OK) && (rsp_addr_ff != '0), "failed response carries an address")

endmodule

// ===== verif/per_hart_page_free_list_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the per-hart page free-list allocator.

module per_hart_page_free_list_tb;
   import phpfl_pkg::*;

   localparam int NUM_HARTS = 8;
   localparam int NUM_PAGES = 1024;
   localparam int IDX_W     = $clog2(NUM_PAGES);
   // one past the highest page number that an address can name
   localparam logic [END_W-1:0] PAGE_LIMIT = 45'd1 << FIRST_W;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   addr;
   } page_reply_type;

   // Predicts every reply from the lists it keeps and checks the replies in order.
   class page_pool_scoreboard;
      logic [FIRST_W-1:0] first_page;
      logic [END_W-1:0]   end_page;
      bit                 head_ok[NUM_HARTS];
      bit [IDX_W-1:0]     head_idx[NUM_HARTS];
      bit                 link_ok[NUM_PAGES];
      bit [IDX_W-1:0]     link_idx[NUM_PAGES];
      page_reply_type     replies_due[$];
      int                 errors;

      function new();
         first_page = FIRST_PAGE_RESET;
         end_page   = END_PAGE_RESET;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_FIRST_PAGE) begin
            first_page = data[FIRST_W-1:0];
         end else if (idx == CSR_END_PAGE) begin
            end_page = data[END_W-1:0];
         end
      endfunction

      // Pop the head of one hart's list; return 0 when that list is empty.
      function bit pop_list(int h, output bit [IDX_W-1:0] idx);
         idx = head_idx[h];
         if (!head_ok[h]) return 1'b0;
         head_ok[h]  = link_ok[idx];
         head_idx[h] = link_idx[idx];
         return 1'b1;
      endfunction

      // Apply one accepted word; return the page index pushed or handed out, else -1.
      function int note_request(logic func, logic [HART_W-1:0] hart,
                                logic [ADDR_W-1:0] addr);
         logic [FIRST_W-1:0] page;
         logic [ADDR_W:0]    sum;
         bit [IDX_W-1:0]     idx;
         bit                 got;
         page_reply_type     rep;
         int                 taken;
         page  = addr[ADDR_W-1:PAGE_SHIFT];
         rep   = '{STATUS_OK, '0};
         taken = -1;
         idx   = '0;
         if (func == FUNC_FREE) begin
            // reject unless aligned, in bounds and inside the link memory
            if (hart >= NUM_HARTS || addr[PAGE_SHIFT-1:0] != '0 || page < first_page ||
                {1'b0, page} >= end_page || page - first_page >= NUM_PAGES) begin
               rep.status = STATUS_BADADDR;
            end else begin
               idx           = IDX_W'(page - first_page);
               link_ok[idx]  = head_ok[hart];
               link_idx[idx] = head_idx[hart];
               head_ok[hart]  = 1'b1;
               head_idx[hart] = idx;
               taken = idx;
            end
         end else begin
            // own list first, then steal scanning from hart 0 upward
            got = 1'b0;
            if (hart < NUM_HARTS) got = pop_list(hart, idx);
            for (int h = 0; h < NUM_HARTS; h++) begin
               if (!got && h != hart) got = pop_list(h, idx);
            end
            if (got) begin
               sum      = first_page + idx;
               rep.addr = ADDR_W'(sum << PAGE_SHIFT);
               taken    = idx;
            end else begin
               rep.status = STATUS_NOMEM;
            end
         end
         replies_due.push_back(rep);
         return taken;
      endfunction

      function int waiting();
         return replies_due.size();
      endfunction

      task report(string what);
         if (errors < 40) $display("mismatch at %0t ns: %s", $time, what);
         errors++;
      endtask

      task check_response(logic [STATUS_W-1:0] status, logic [ADDR_W-1:0] addr);
         page_reply_type want;
         if (replies_due.size() == 0) begin
            report($sformatf("reply with none due, status %0d address %h", status, addr));
            return;
         end
         want = replies_due.pop_front();
         if (status !== want.status)
            report($sformatf("status %0d, predicted %0d", status, want.status));
         if (addr !== want.addr)
            report($sformatf("address %h, predicted %h", addr, want.addr));
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic                  req_func;
   logic [HART_W-1:0]     req_hart;
   logic [ADDR_W-1:0]     req_page_address;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ADDR_W-1:0]     rsp_alloc_address;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   page_pool_scoreboard pool;
   bit                  page_held[NUM_PAGES];  // pages software holds and may free
   bit                  steady;                // no idling on either side
   int                  ready_hold;

   per_hart_page_free_list #(
      .NUM_HARTS(NUM_HARTS),
      .NUM_PAGES(NUM_PAGES)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_hart         (req_hart),
      .req_page_address (req_page_address),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_alloc_address(rsp_alloc_address),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #(5_000_000);
      $display("FAILURE");
      $finish;
   end

   function automatic logic [ADDR_W-1:0] page_addr(logic [FIRST_W-1:0] page);
      return {page, {PAGE_SHIFT{1'b0}}};
   endfunction

   function automatic logic [ADDR_W-1:0] rand_addr();
      return ADDR_W'({$urandom, $urandom});
   endfunction

   // Build a free address meant to fail one of the checks under the given bounds, or a random one.
   function automatic logic [ADDR_W-1:0] bad_free_addr(logic [FIRST_W-1:0] lo_page,
                                                      logic [END_W-1:0] hi_page);
      logic [FIRST_W-1:0] page;
      logic [END_W-1:0]   above;
      page  = lo_page + $urandom_range(0, NUM_PAGES - 1);
      above = hi_page + $urandom_range(0, 3);
      case ($urandom_range(0, 4))
         0: begin
            return {page, PAGE_SHIFT'($urandom_range(1, (1 << PAGE_SHIFT) - 1))};
         end
         1: begin
            if (lo_page != '0) return page_addr(lo_page - 1'b1 - FIRST_W'($urandom) % lo_page);
            return rand_addr();
         end
         2: begin
            if (above < PAGE_LIMIT) return page_addr(above[FIRST_W-1:0]);
            if (hi_page < PAGE_LIMIT) return page_addr(hi_page[FIRST_W-1:0]);
            return {page, PAGE_SHIFT'($urandom_range(1, (1 << PAGE_SHIFT) - 1))};
         end
         3: begin
            return page_addr(lo_page + NUM_PAGES + $urandom_range(0, 7));
         end
         default: begin
            return rand_addr();
         end
      endcase
   endfunction

   // Present one word, hold it until accepted, then update the predictor.
   task automatic send_req(logic func, logic [HART_W-1:0] hart, logic [ADDR_W-1:0] addr);
      int taken;
      @(negedge clock);
      if (!steady && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_valid        <= 1'b1;
      req_func         <= func;
      req_hart         <= hart;
      req_page_address <= addr;
      do @(posedge clock); while (!req_ready);
      taken = pool.note_request(func, hart, addr);
      if (taken >= 0) page_held[taken] = (func == FUNC_ALLOC);
   endtask

   // Mostly frees of held pages and allocs, with some malformed frees mixed in.
   task automatic send_random();
      logic [FIRST_W-1:0] lo_page;
      logic [END_W-1:0]   hi_page;
      longint unsigned    span;
      int                 pick;
      int                 idx;
      int                 cand;
      lo_page = pool.first_page;
      hi_page = pool.end_page;
      span    = (hi_page > lo_page) ? hi_page - lo_page : 0;
      if (span > NUM_PAGES) span = NUM_PAGES;
      pick = $urandom_range(0, 99);
      idx  = -1;
      if (pick < 40 && span > 0) begin
         for (int tries = 0; tries < 8 && idx < 0; tries++) begin
            cand = $urandom_range(0, int'(span) - 1);
            if (page_held[cand]) idx = cand;
         end
      end
      if (idx >= 0) begin
         send_req(FUNC_FREE, HART_W'($urandom), page_addr(lo_page + idx));
      end else if (pick >= 40 && pick < 55) begin
         send_req(FUNC_FREE, HART_W'($urandom), bad_free_addr(lo_page, hi_page));
      end else begin
         send_req(FUNC_ALLOC, HART_W'($urandom), rand_addr());
      end
   endtask

   // Drop valid and wait until every reply has come back.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pool.waiting() != 0) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_we <= 1'b0;
      pool.write_reg(idx, data);
   endtask

   // Stall the reply side in short random bursts.
   always @(negedge clock) begin
      if (reset || steady) begin
         rsp_ready <= 1'b1;
      end else if (ready_hold > 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(0, 5) == 0) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 2);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Check each accepted reply word.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) pool.check_response(rsp_status, rsp_alloc_address);
   end

   initial begin
      logic [FIRST_W-1:0] fp;
      logic [FIRST_W-1:0] rnd_first;
      pool             = new();
      fp               = FIRST_PAGE_RESET;
      steady           = 1'b0;
      ready_hold       = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_func         = FUNC_ALLOC;
      req_hart         = '0;
      req_page_address = '0;
      rsp_ready        = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_FIRST_PAGE;
      csr_wdata        = '0;
      foreach (page_held[i]) page_held[i] = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty lists, field extremes, each rejection, double free, steals
      send_req(FUNC_ALLOC, 0, '0);
      send_req(FUNC_ALLOC, 7, '1);
      send_req(FUNC_FREE, 0, page_addr(fp));
      send_req(FUNC_FREE, 0, page_addr(fp + 1));
      send_req(FUNC_FREE, 3, page_addr(fp + NUM_PAGES - 1));
      send_req(FUNC_FREE, 7, page_addr(fp + 5));
      send_req(FUNC_FREE, 1, page_addr(fp + 5));
      send_req(FUNC_FREE, 2, {fp, 12'h800});
      send_req(FUNC_FREE, 2, page_addr(fp - 1));
      send_req(FUNC_FREE, 4, page_addr(fp + NUM_PAGES));
      send_req(FUNC_FREE, 4, page_addr(END_PAGE_RESET[FIRST_W-1:0]));
      send_req(FUNC_FREE, 6, '0);
      send_req(FUNC_FREE, 6, '1);
      send_req(FUNC_ALLOC, 0, '1);
      send_req(FUNC_ALLOC, 0, '0);
      send_req(FUNC_ALLOC, 0, '0);
      send_req(FUNC_ALLOC, 6, '0);
      send_req(FUNC_ALLOC, 7, '0);
      send_req(FUNC_ALLOC, 2, '0);
      send_req(FUNC_FREE, 7, page_addr(fp + 9));
      send_req(FUNC_ALLOC, 0, '0);
      settle();

      // widest window: first page zero, end at the top of the page space
      write_csr(CSR_FIRST_PAGE, '0);
      write_csr(CSR_END_PAGE, PAGE_LIMIT);
      repeat (130) send_random();
      settle();

      // top page only; pages still listed wrap past the address width
      write_csr(CSR_FIRST_PAGE, CSR_DATA_W'(PAGE_LIMIT - 1));
      repeat (60) send_random();
      settle();

      // random base with a window of 50 to 1500 pages, which may reach past the link memory
      rnd_first = FIRST_W'(FIRST_W'({$urandom, $urandom}) % (PAGE_LIMIT - 2048));
      write_csr(CSR_FIRST_PAGE, CSR_DATA_W'(rnd_first));
      write_csr(CSR_END_PAGE, CSR_DATA_W'(rnd_first) + $urandom_range(50, 1500));
      repeat (110) send_random();
      settle();

      // empty window: every free is rejected while allocs drain the lists
      write_csr(CSR_END_PAGE, '0);
      repeat (40) send_random();
      settle();

      // back to the reset bounds, full rate on both sides
      write_csr(CSR_FIRST_PAGE, CSR_DATA_W'(FIRST_PAGE_RESET));
      write_csr(CSR_END_PAGE, CSR_DATA_W'(END_PAGE_RESET));
      steady = 1'b1;
      repeat (110) send_random();
      settle();

      repeat (NUM_HARTS + 8) @(posedge clock);
      if (pool.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
